// File: rtl/core/xed_pkg.sv
// ----------------------------------------------------------------------------
// xed_pkg
// Shared types, constants and functions of the XML character reference decoder.
// ----------------------------------------------------------------------------
package xed_pkg;

    localparam int WINDOW = 16;

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_X_LO = 8'h78;
    localparam logic [7:0] CH_X_UP = 8'h58;

    localparam int NNAMES = 6;

    localparam logic [20:0] CP_MAX = 21'h10FFFF;
    localparam logic [20:0] SUR_LO = 21'h00D800;
    localparam logic [20:0] SUR_HI = 21'h00DFFF;

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_PROC, S_REP, S_FRD, S_FEM, S_FIN
    } t_state;

    typedef enum logic [2:0] {
        ACT_NONE, ACT_START, ACT_EMIT, ACT_APPEND, ACT_ACCEPT, ACT_REJECT
    } t_act;

    typedef struct packed {
        logic accept_in;
        logic rd_scan;
        t_act act;
        logic rep_push;
        logic fl_rd;
        logic fl_push;
        logic fl_end;
        logic fin_push;
    } t_cmd;

    typedef struct packed {
        logic q_empty;
        logic pc_zero;
        logic pc_full;
        logic b_amp;
        logic b_semi;
        logic dec_ok;
        logic can_push;
        logic out_free;
        logic hold_valid;
        logic rep_done;
        logic fl_done;
        logic eot;
    } t_sts;

    typedef struct packed {
        logic [2:0]  len;
        logic [31:0] b;
    } t_utf8;

    typedef struct packed {
        logic       ok;
        logic [3:0] d;
    } t_digit;

    // Names left aligned in 32 bits, first character in the top byte.
    function automatic logic [31:0] name_str(input int idx);
        logic [31:0] s;
        case (idx)
            0:       s = {"amp", 8'h00};
            1:       s = {"lt", 16'h0000};
            2:       s = {"gt", 16'h0000};
            3:       s = "quot";
            4:       s = "apos";
            5:       s = "nbsp";
            default: s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [2:0] name_len(input int idx);
        logic [2:0] l;
        case (idx)
            0:       l = 3'd3;
            1, 2:    l = 3'd2;
            3, 4, 5: l = 3'd4;
            default: l = 3'd0;
        endcase
        return l;
    endfunction

    function automatic logic [7:0] name_char(input int idx, input logic [1:0] k);
        logic [31:0] s;
        s = name_str(idx);
        return s[8 * (3 - int'(k)) +: 8];
    endfunction

    function automatic logic [20:0] name_code(input int idx);
        logic [20:0] c;
        case (idx)
            0:       c = 21'h26;
            1:       c = 21'h3C;
            2:       c = 21'h3E;
            3:       c = 21'h22;
            4:       c = 21'h27;
            5:       c = 21'hA0;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic t_digit digit_val(input logic [7:0] c, input logic hex);
        t_digit r;
        r.ok = 1'b0;
        r.d  = '0;
        if (c >= "0" && c <= "9") begin
            r.ok = 1'b1;
            r.d  = 4'(c - "0");
        end else if (hex && c >= "a" && c <= "f") begin
            r.ok = 1'b1;
            r.d  = 4'(c - "a" + 8'd10);
        end else if (hex && c >= "A" && c <= "F") begin
            r.ok = 1'b1;
            r.d  = 4'(c - "A" + 8'd10);
        end
        return r;
    endfunction

    // Byte 0 of the encoding sits in the lowest bits.
    function automatic t_utf8 utf8_enc(input logic [20:0] cp);
        t_utf8 r;
        r.b = '0;
        if (cp < 21'h80) begin
            r.len = 3'd1;
            r.b[7:0] = cp[7:0];
        end else if (cp < 21'h800) begin
            r.len = 3'd2;
            r.b[7:0]  = {3'b110, cp[10:6]};
            r.b[15:8] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            r.len = 3'd3;
            r.b[7:0]   = {4'b1110, cp[15:12]};
            r.b[15:8]  = {2'b10, cp[11:6]};
            r.b[23:16] = {2'b10, cp[5:0]};
        end else begin
            r.len = 3'd4;
            r.b[7:0]   = {5'b11110, cp[20:18]};
            r.b[15:8]  = {2'b10, cp[17:12]};
            r.b[23:16] = {2'b10, cp[11:6]};
            r.b[31:24] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

endpackage

// File: rtl/core/xml_entity_decoder_top.sv
// ----------------------------------------------------------------------------
// xml_entity_decoder_top
// Streaming XML character reference decoder with UTF-8 output.
// ----------------------------------------------------------------------------
// Input beats on the s_axis channel carry one text byte each; tlast marks the
// final byte of a text. Output beats on m_axis carry decoded bytes; tlast is
// set on the last byte caused by an input beat and tuser on the last byte of
// the decoded text. An input beat may cause no output beat at all.
// References (amp, lt, gt, quot, apos, nbsp, decimal and hex numeric) are
// replaced by their UTF-8 bytes; a rejected reference passes its ampersand
// and the bytes behind it are scanned again.
// One byte is taken at a time. After a plain byte is accepted, the block
// reads and scans it, reads again to find the queue empty and releases the
// held output byte before it takes the next one. Every byte scanned again
// adds a read and a scan step, every replacement byte a push step and every
// flushed byte a read and a push step. The scan loop reads the byte buffer
// through its single registered read port. The newest byte is held back
// until the step ends.
// Reset empties the buffer and output stage; no clearing pass is needed.
// When the receiver stalls, the block holds its output beat and waits at
// its next byte push until space frees up; s_axis_tready stays low meanwhile.
// ----------------------------------------------------------------------------
module xml_entity_decoder_top #(
    parameter int WINDOW = xed_pkg::WINDOW
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,
    output logic       m_axis_tuser    // [0] text_done
);

    xed_pkg::t_cmd cmd;
    xed_pkg::t_sts sts;

    xed_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    xed_dp #(.WINDOW(WINDOW)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_byte      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_byte  (m_axis_tdata),
        .o_out_last  (m_axis_tlast),
        .o_out_done  (m_axis_tuser)
    );

endmodule

// File: rtl/core/xed_ram.sv
// ----------------------------------------------------------------------------
// xed_ram
// Generic single write, single read RAM with a registered read port.
// ----------------------------------------------------------------------------
module xed_ram #(
    parameter int W = 8,
    parameter int D = 32
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/xed_dp.sv
// ----------------------------------------------------------------------------
// xed_dp
// Datapath: byte buffer, pointers, reference decoder, hold and output stage.
// ----------------------------------------------------------------------------
module xed_dp #(
    parameter int WINDOW = xed_pkg::WINDOW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  xed_pkg::t_cmd i_cmd,
    output xed_pkg::t_sts o_sts,
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [7:0]    o_out_byte,
    output logic          o_out_last,
    output logic          o_out_done
);

    localparam int PW = $clog2(WINDOW + 1);
    localparam int D  = 1 << PW;
    localparam int QW = $clog2(WINDOW + 2);

    // The buffer holds the pending reference from r_h (r_pc bytes) followed by
    // the bytes still to be scanned (r_qn bytes).
    logic [PW-1:0] r_h, r_tail, r_pc, r_fcnt;
    logic [QW-1:0] r_qn;
    logic          r_eot;
    logic [7:0]    b;
    logic [PW-1:0] scan_addr, rd_addr;
    logic          re;

    // Decoder state of the pending reference.
    logic [xed_pkg::NNAMES-1:0] r_nm;
    logic                       r_num, r_hex, r_dig, r_err;
    logic [20:0]                r_val;

    logic [31:0] r_rep;
    logic [2:0]  r_rlen;
    logic [1:0]  r_ridx;

    logic        r_hold_v, r_out_v, r_out_last, r_out_td;
    logic [7:0]  r_hold, r_out_b;

    logic [PW-1:0]  k, nlen;
    logic [24:0]    nv;
    xed_pkg::t_digit dg;
    logic           named_ok, num_ok, out_free, push_en;
    logic [7:0]     push_byte;
    logic [20:0]    cp;
    xed_pkg::t_utf8 enc;

    assign scan_addr = r_h + r_pc;
    assign re        = i_cmd.rd_scan | i_cmd.fl_rd;
    assign rd_addr   = i_cmd.fl_rd ? (r_h + r_fcnt) : scan_addr;

    xed_ram #(.W(8), .D(D)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept_in),
        .i_waddr (r_tail),
        .i_wdata (i_byte),
        .i_re    (re),
        .i_raddr (rd_addr),
        .o_rdata (b)
    );

    assign k    = r_pc - PW'(1);
    assign nlen = r_pc - PW'(1);
    assign dg   = xed_pkg::digit_val(b, r_hex);
    assign nv   = r_hex ? ({4'b0, r_val} << 4) + 25'(dg.d)
                        : ({4'b0, r_val} << 3) + ({4'b0, r_val} << 1) + 25'(dg.d);

    always_comb begin
        named_ok = 1'b0;
        cp       = r_val;
        for (int j = 0; j < xed_pkg::NNAMES; j++) begin
            if (r_nm[j] && nlen == PW'(xed_pkg::name_len(j))) begin
                named_ok = 1'b1;
                cp       = xed_pkg::name_code(j);
            end
        end
    end

    assign num_ok = r_num && !r_err && r_dig && (r_val != '0)
                    && !(r_val >= xed_pkg::SUR_LO && r_val <= xed_pkg::SUR_HI);
    assign enc    = xed_pkg::utf8_enc(cp);

    assign out_free = !r_out_v || i_out_ready;

    always_comb begin
        push_en   = 1'b0;
        push_byte = b;
        if (i_cmd.act == xed_pkg::ACT_EMIT) begin
            push_en = 1'b1;
        end else if (i_cmd.act == xed_pkg::ACT_REJECT) begin
            push_en   = 1'b1;
            push_byte = xed_pkg::CH_AMP;
        end else if (i_cmd.rep_push) begin
            push_en   = 1'b1;
            push_byte = r_rep[8 * int'(r_ridx) +: 8];
        end else if (i_cmd.fl_push) begin
            push_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h      <= '0;
            r_tail   <= '0;
            r_pc     <= '0;
            r_qn     <= '0;
            r_fcnt   <= '0;
            r_eot    <= 1'b0;
            r_ridx   <= '0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cmd.accept_in) begin
                r_tail <= r_tail + PW'(1);
                r_qn   <= r_qn + QW'(1);
                r_eot  <= i_last;
                r_fcnt <= '0;
            end
            case (i_cmd.act)
                xed_pkg::ACT_START: begin
                    r_pc <= PW'(1);
                    r_qn <= r_qn - QW'(1);
                end
                xed_pkg::ACT_EMIT: begin
                    r_h  <= r_h + PW'(1);
                    r_qn <= r_qn - QW'(1);
                end
                xed_pkg::ACT_APPEND: begin
                    r_pc <= r_pc + PW'(1);
                    r_qn <= r_qn - QW'(1);
                end
                xed_pkg::ACT_ACCEPT: begin
                    r_h    <= r_h + r_pc + PW'(1);
                    r_pc   <= '0;
                    r_qn   <= r_qn - QW'(1);
                    r_ridx <= '0;
                end
                xed_pkg::ACT_REJECT: begin
                    // The bytes after the ampersand go back in front of the queue.
                    r_h  <= r_h + PW'(1);
                    r_pc <= '0;
                    r_qn <= r_qn + QW'(r_pc) - QW'(1);
                end
                default: ;
            endcase
            if (i_cmd.rep_push) begin
                r_ridx <= r_ridx + 2'd1;
            end
            if (i_cmd.fl_rd) begin
                r_fcnt <= r_fcnt + PW'(1);
            end
            if (i_cmd.fl_end) begin
                r_h  <= r_h + r_pc;
                r_pc <= '0;
            end
            // One byte is held back so that the last byte of a run is known.
            if (push_en) begin
                if (r_hold_v) begin
                    r_out_v    <= 1'b1;
                    r_out_b    <= r_hold;
                    r_out_last <= 1'b0;
                    r_out_td   <= 1'b0;
                end else if (r_out_v && i_out_ready) begin
                    r_out_v <= 1'b0;
                end
                r_hold   <= push_byte;
                r_hold_v <= 1'b1;
            end else if (i_cmd.fin_push) begin
                r_out_v    <= 1'b1;
                r_out_b    <= r_hold;
                r_out_last <= 1'b1;
                r_out_td   <= r_eot;
                r_hold_v   <= 1'b0;
            end else if (r_out_v && i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.act == xed_pkg::ACT_START) begin
            r_nm  <= '1;
            r_num <= 1'b0;
            r_hex <= 1'b0;
            r_dig <= 1'b0;
            r_err <= 1'b0;
            r_val <= '0;
        end else if (i_cmd.act == xed_pkg::ACT_APPEND) begin
            for (int j = 0; j < xed_pkg::NNAMES; j++) begin
                r_nm[j] <= r_nm[j] && (k < PW'(xed_pkg::name_len(j)))
                           && (b == xed_pkg::name_char(j, k[1:0]));
            end
            if (k == '0) begin
                r_num <= (b == xed_pkg::CH_HASH);
            end else if (r_num && !r_err) begin
                if (k == PW'(1) && (b == xed_pkg::CH_X_LO || b == xed_pkg::CH_X_UP)) begin
                    r_hex <= 1'b1;
                end else if (!dg.ok || nv > 25'(xed_pkg::CP_MAX)) begin
                    r_err <= 1'b1;
                end else begin
                    r_val <= nv[20:0];
                    r_dig <= 1'b1;
                end
            end
        end
        if (i_cmd.act == xed_pkg::ACT_ACCEPT) begin
            r_rep  <= enc.b;
            r_rlen <= enc.len;
        end
    end

    assign o_sts.q_empty    = (r_qn == '0);
    assign o_sts.pc_zero    = (r_pc == '0);
    assign o_sts.pc_full    = (r_pc == PW'(WINDOW));
    assign o_sts.b_amp      = (b == xed_pkg::CH_AMP);
    assign o_sts.b_semi     = (b == xed_pkg::CH_SEMI);
    assign o_sts.dec_ok     = named_ok || num_ok;
    assign o_sts.can_push   = !r_hold_v || out_free;
    assign o_sts.out_free   = out_free;
    assign o_sts.hold_valid = r_hold_v;
    assign o_sts.rep_done   = ({1'b0, r_ridx} == r_rlen - 3'd1);
    // r_fcnt counts the bytes already read, so the last one is in b when it
    // reaches the pending count.
    assign o_sts.fl_done    = (r_fcnt == r_pc);
    assign o_sts.eot        = r_eot;

    assign o_out_valid = r_out_v;
    assign o_out_byte  = r_out_b;
    assign o_out_last  = r_out_last;
    assign o_out_done  = r_out_td;

    a_pc_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_pc) <= WINDOW)
        else $error("pending count above window");

    a_held_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_pc) + int'(r_qn) <= WINDOW + 1)
        else $error("buffer holds more bytes than it can");

    a_ptr_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail == r_h + r_pc + PW'(r_qn))
        else $error("buffer pointers disagree");

endmodule

// File: rtl/core/xed_ctrl.sv
// ----------------------------------------------------------------------------
// xed_ctrl
// Controller: sequences accept, scan, replace, reject and flush steps.
// ----------------------------------------------------------------------------
module xed_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  xed_pkg::t_sts i_sts,
    output xed_pkg::t_cmd o_cmd
);

    xed_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= xed_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.act  = xed_pkg::ACT_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            xed_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept_in = 1'b1;
                    n_state = xed_pkg::S_RD;
                end
            end
            xed_pkg::S_RD: begin
                if (!i_sts.q_empty) begin
                    o_cmd.rd_scan = 1'b1;
                    n_state = xed_pkg::S_PROC;
                end else if (i_sts.eot && !i_sts.pc_zero) begin
                    n_state = xed_pkg::S_FRD;
                end else begin
                    n_state = xed_pkg::S_FIN;
                end
            end
            xed_pkg::S_PROC: begin
                if (i_sts.pc_zero) begin
                    if (i_sts.b_amp) begin
                        o_cmd.act = xed_pkg::ACT_START;
                        n_state = xed_pkg::S_RD;
                    end else if (i_sts.can_push) begin
                        o_cmd.act = xed_pkg::ACT_EMIT;
                        n_state = xed_pkg::S_RD;
                    end
                end else if (i_sts.b_semi && i_sts.dec_ok) begin
                    o_cmd.act = xed_pkg::ACT_ACCEPT;
                    n_state = xed_pkg::S_REP;
                end else if (!i_sts.b_semi && !i_sts.pc_full) begin
                    o_cmd.act = xed_pkg::ACT_APPEND;
                    n_state = xed_pkg::S_RD;
                end else if (i_sts.can_push) begin
                    o_cmd.act = xed_pkg::ACT_REJECT;
                    n_state = xed_pkg::S_RD;
                end
            end
            xed_pkg::S_REP: begin
                if (i_sts.can_push) begin
                    o_cmd.rep_push = 1'b1;
                    if (i_sts.rep_done) begin
                        n_state = xed_pkg::S_RD;
                    end
                end
            end
            xed_pkg::S_FRD: begin
                o_cmd.fl_rd = 1'b1;
                n_state = xed_pkg::S_FEM;
            end
            xed_pkg::S_FEM: begin
                if (i_sts.can_push) begin
                    o_cmd.fl_push = 1'b1;
                    if (i_sts.fl_done) begin
                        o_cmd.fl_end = 1'b1;
                        n_state = xed_pkg::S_FIN;
                    end else begin
                        n_state = xed_pkg::S_FRD;
                    end
                end
            end
            xed_pkg::S_FIN: begin
                if (!i_sts.hold_valid) begin
                    n_state = xed_pkg::S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.fin_push = 1'b1;
                    n_state = xed_pkg::S_IDLE;
                end
            end
            default: n_state = xed_pkg::S_IDLE;
        endcase
    end

    a_idle_no_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == xed_pkg::S_IDLE) |-> i_sts.q_empty && !i_sts.hold_valid)
        else $error("idle with work left");

    a_flush_needs_eot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == xed_pkg::S_FRD) |-> i_sts.eot && !i_sts.pc_zero)
        else $error("flush without end of text");

    a_accept_then_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.act == xed_pkg::ACT_ACCEPT) |=> (r_state == xed_pkg::S_REP))
        else $error("replacement not emitted after accept");

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the XML character reference decoder. Text bytes go
// in on the slave stream with random gaps; a predictor of the decoder runs on
// every accepted beat and queues the decoded bytes it expects, which are
// compared with the master stream beats under random backpressure.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_text_beat;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       done;
    } t_dec_beat;

    logic       i_clk;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic       m_axis_tuser;

    t_text_beat text_q[$];
    t_dec_beat  decoded_q[$];
    int         errors = 0;
    int         accepted = 0;
    int         total = 0;
    bit         hold_until_drained = 0;
    int         send_wait = 0;
    int         recv_wait = 0;

    // Predictor state: held ampersand and the bytes behind it.
    logic [7:0] held[0:xed_pkg::WINDOW];
    int         held_cnt = 0;

    xml_entity_decoder_top DUT (.*);

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    function automatic int utf8_bytes(input int unsigned cp, output logic [7:0] r[4]);
        if (cp < 'h80) begin
            r[0] = cp[7:0]; return 1;
        end
        if (cp < 'h800) begin
            r[0] = 8'hC0 | 8'(cp >> 6); r[1] = 8'h80 | 8'(cp & 'h3F); return 2;
        end
        if (cp < 'h10000) begin
            r[0] = 8'hE0 | 8'(cp >> 12); r[1] = 8'h80 | 8'((cp >> 6) & 'h3F);
            r[2] = 8'h80 | 8'(cp & 'h3F); return 3;
        end
        r[0] = 8'hF0 | 8'((cp >> 18) & 7); r[1] = 8'h80 | 8'((cp >> 12) & 'h3F);
        r[2] = 8'h80 | 8'((cp >> 6) & 'h3F); r[3] = 8'h80 | 8'(cp & 'h3F);
        return 4;
    endfunction

    // Compares the held name byte by byte, so that a zero byte counts too.
    function automatic bit held_is(input string s);
        if (held_cnt - 1 != s.len()) return 0;
        for (int j = 0; j < s.len(); j++)
            if (held[j + 1] != s[j]) return 0;
        return 1;
    endfunction

    // Decodes held[1..held_cnt-1]; returns 0 when the reference is rejected.
    function automatic int resolve_ref(output logic [7:0] r[4]);
        int unsigned v;
        int unsigned d;
        int i;
        bit hex;
        logic [7:0] c;
        if (held_is("amp"))  begin r[0] = "&";   return 1; end
        if (held_is("lt"))   begin r[0] = "<";   return 1; end
        if (held_is("gt"))   begin r[0] = ">";   return 1; end
        if (held_is("quot")) begin r[0] = 8'h22; return 1; end
        if (held_is("apos")) begin r[0] = 8'h27; return 1; end
        if (held_is("nbsp")) return utf8_bytes('hA0, r);
        if (held_cnt - 1 <= 1 || held[1] != xed_pkg::CH_HASH) return 0;
        hex = (held[2] == xed_pkg::CH_X_LO || held[2] == xed_pkg::CH_X_UP);
        i = hex ? 3 : 2;
        if (i >= held_cnt) return 0;
        v = 0;
        for (; i < held_cnt; i++) begin
            c = held[i];
            if (c >= "0" && c <= "9") d = c - "0";
            else if (hex && c >= "a" && c <= "f") d = c - "a" + 10;
            else if (hex && c >= "A" && c <= "F") d = c - "A" + 10;
            else return 0;
            v = v * (hex ? 16 : 10) + d;
            if (v > xed_pkg::CP_MAX) return 0;
        end
        if (v == 0 || (v >= xed_pkg::SUR_LO && v <= xed_pkg::SUR_HI)) return 0;
        return utf8_bytes(v, r);
    endfunction

    task automatic predict_decode(input t_text_beat tb);
        logic [7:0] work[$];
        logic [7:0] outb[$];
        logic [7:0] rep[4];
        logic [7:0] b;
        logic [7:0] rescan[$];
        int n;
        int i;
        t_dec_beat e;
        work = {work, tb.data};
        while (work.size() > 0) begin
            b = work.pop_front();
            if (held_cnt == 0) begin
                if (b == xed_pkg::CH_AMP) held[held_cnt++] = b;
                else outb = {outb, b};
                continue;
            end
            if (b == xed_pkg::CH_SEMI) begin
                n = resolve_ref(rep);
                if (n != 0) begin
                    for (i = 0; i < n; i++) outb = {outb, rep[i]};
                    held_cnt = 0;
                    continue;
                end
            end else if (held_cnt < xed_pkg::WINDOW) begin
                held[held_cnt++] = b;
                continue;
            end
            // Rejected: pass the ampersand, scan the rest again.
            outb = {outb, xed_pkg::CH_AMP};
            rescan = {};
            for (i = 1; i < held_cnt; i++) rescan = {rescan, held[i]};
            rescan = {rescan, b};
            work = {rescan, work};
            held_cnt = 0;
        end
        if (tb.last) begin
            for (i = 0; i < held_cnt; i++) outb = {outb, held[i]};
            held_cnt = 0;
        end
        foreach (outb[k]) begin
            e.data = outb[k];
            e.last = (k == outb.size() - 1);
            e.done = e.last && tb.last;
            decoded_q = {decoded_q, e};
        end
    endtask

    // Driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
            send_wait     <= $urandom_range(0, 13);
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_decode('{s_axis_tdata, s_axis_tlast});
                accepted++;
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // hold the beat
            end else if (send_wait > 0) begin
                s_axis_tvalid <= 1'b0;
                send_wait     <= send_wait - 1;
            end else if (hold_until_drained && accepted == 200 && decoded_q.size() > 0) begin
                s_axis_tvalid <= 1'b0;
            end else if (text_q.size() > 0) begin
                t_text_beat nb;
                nb = text_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= nb.data;
                s_axis_tlast  <= nb.last;
                send_wait     <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_wait     <= $urandom_range(0, 13);
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (decoded_q.size() == 0) begin
                    $display("%0t: unexpected beat: expected none, actual %h/%b/%b", $time,
                             m_axis_tdata, m_axis_tlast, m_axis_tuser);
                    errors++;
                end else begin
                    t_dec_beat e;
                    e = decoded_q.pop_front();
                    if (e.data != m_axis_tdata) begin
                        $display("%0t: out_byte expected %h actual %h", $time, e.data,
                                 m_axis_tdata);
                        errors++;
                    end
                    if (e.last != m_axis_tlast) begin
                        $display("%0t: last_of_run expected %b actual %b", $time, e.last,
                                 m_axis_tlast);
                        errors++;
                    end
                    if (e.done != m_axis_tuser) begin
                        $display("%0t: text_done expected %b actual %b", $time, e.done,
                                 m_axis_tuser);
                        errors++;
                    end
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                recv_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
                m_axis_tready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait     <= recv_wait - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic add_text(input string s, input bit ends);
        t_text_beat tb;
        for (int i = 0; i < s.len(); i++) begin
            tb = '{s[i], ends && (i == s.len() - 1)};
            text_q = {text_q, tb};
        end
        total += s.len();
    endtask

    function automatic string rand_piece();
        int k;
        string s;
        string hx;
        k = $urandom_range(0, 15);
        case (k)
            0: s = "&amp;";
            1: s = "&lt;";
            2: s = "&gt;";
            3: s = "&quot;";
            4: s = "&apos;";
            5: s = "&nbsp;";
            6: s = $sformatf("&#%0d;", $urandom_range(1, 'h10FFFF));
            7: begin
                hx = $sformatf("%0h", $urandom_range(1, 'h10FFFF));
                if ($urandom_range(0, 1)) hx = hx.toupper();
                s = {$urandom_range(0, 1) ? "&#x" : "&#X", hx, ";"};
            end
            8: s = $sformatf("&#%0d;", $urandom_range(0, 80000));
            9: s = $sformatf("&#x%0h;", $urandom_range('hD700, 'hE100));
            10: s = {"&", $urandom_range(0, 1) ? "am" : "#x", ";"};
            11: s = "&&lt;";
            12: s = "&#xZ1;";
            13: s = "&abcdefghijklmnopq;";
            14: s = $sformatf("&#%0d;", $urandom_range(1114000, 99999999));
            default: s = "";
        endcase
        if (s.len() > 0 && $urandom_range(0, 5) == 0)
            s = s.substr(0, $urandom_range(0, s.len() - 2));
        return s;
    endfunction

    initial begin
        string s;
        t_text_beat tb;
        i_rst_n = 1'b0;
        add_text("&amp;&lt;&gt;", 0);
        add_text("&quot;&apos;&nbsp;", 1);
        add_text("&#x10FFFF;&#65;&;", 1);
        add_text("&#0;&#xD800;&#x110000;&x", 1);
        tb = '{8'hFF, 1'b0};
        text_q = {text_q, tb};
        tb = '{8'h00, 1'b1};
        text_q = {text_q, tb};
        total += 2;
        add_text("&", 1);
        while (total < 380) begin
            s = "";
            repeat ($urandom_range(1, 6)) begin
                if ($urandom_range(0, 2) == 0)
                    s = {s, string'(8'($urandom_range(0, 255)))};
                else
                    s = {s, rand_piece()};
            end
            add_text(s, $urandom_range(0, 3) == 0);
        end
        add_text("x", 1);
        hold_until_drained = 1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (text_q.size() > 0 || s_axis_tvalid || decoded_q.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && decoded_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
